### src/cpcs_pkg.sv
// cpcs_pkg: shared types and constants for the pitch cv calibrate/smooth block
// used by cpcs_ctrl, cpcs_dpath, cv_pitch_calibrate_smooth and cpcs_checker
// no dependencies

package cpcs_pkg;

   // field widths
   localparam int unsigned SampleWidth = 16;
   localparam int unsigned OffsetWidth = 16;
   localparam int unsigned GainWidth   = 32;
   localparam int unsigned VoltWidth   = 19;
   localparam int unsigned ReqDataWidth = 16;
   localparam int unsigned RspDataWidth = 24;
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 32;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CsrCalOffset = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrCalGain   = 1'd1;

   // Q3.16 constants
   localparam logic [VoltWidth-1:0] VoltMax    = 19'd327680; // 5 V
   localparam logic [VoltWidth-1:0] OutBias    = 19'd131072; // 2 V
   localparam logic signed [19:0]   JumpLimit  = 20'sd2731;  // 1/24 V
   localparam logic signed [15:0]   SmoothCoef = 16'sd13107; // 0.2

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_STEP,
      ST_WB
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;     // sample transfer, form the offset-corrected count
      logic mul;      // register count times gain
      logic step;     // clamp, jump test, smoothing product
      logic wb;       // update held value and output register
   } cmd_type;

endpackage

### src/cpcs_ctrl.sv
// cpcs_ctrl: sequencing state machine and output valid flag
// depends on cpcs_pkg

module cpcs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output cpcs_pkg::cmd_type cmd
);

   cpcs_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                wb_go;

   // write-back may proceed once the output register is free or being drained
   assign wb_go = (state_ff == cpcs_pkg::ST_WB) && (!rsp_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cpcs_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = cpcs_pkg::ST_MUL;
         end
         cpcs_pkg::ST_MUL:  state_in = cpcs_pkg::ST_STEP;
         cpcs_pkg::ST_STEP: state_in = cpcs_pkg::ST_WB;
         cpcs_pkg::ST_WB: begin
            if (wb_go) state_in = cpcs_pkg::ST_IDLE;
         end
         default: state_in = cpcs_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         cpcs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         cpcs_pkg::ST_MUL:  cmd.mul  = 1'b1;
         cpcs_pkg::ST_STEP: cmd.step = 1'b1;
         cpcs_pkg::ST_WB:   cmd.wb   = wb_go;
         default: begin
            req_tready = 1'b0;
            cmd        = '0;
         end
      endcase
   end

   // output valid: set on write-back, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (wb_go) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpcs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/cpcs_dpath.sv
// cpcs_dpath: calibration registers, scaling multiply, jump test, smoothing
// depends on cpcs_pkg

module cpcs_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cpcs_pkg::cmd_type                    cmd,
   input  logic [cpcs_pkg::SampleWidth-1:0]     sample,
   input  logic                                 csr_we,
   input  logic [cpcs_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [cpcs_pkg::CsrDataWidth-1:0]    csr_wdata,
   output logic [cpcs_pkg::VoltWidth-1:0]       pitch_volts
);

   localparam int unsigned ProdWidth = cpcs_pkg::SampleWidth + cpcs_pkg::GainWidth;

   logic [cpcs_pkg::OffsetWidth-1:0] cal_offset_ff;
   logic [cpcs_pkg::GainWidth-1:0]   cal_gain_ff;
   logic [cpcs_pkg::SampleWidth-1:0] count_ff, count_in;
   logic [ProdWidth-1:0]             prod_ff;
   logic [cpcs_pkg::VoltWidth-1:0]   volts_ff, volts_in;
   logic                             jump_ff, jump_in;
   logic signed [28:0]               sprod_ff, sprod_in;
   logic [cpcs_pkg::VoltWidth-1:0]   held_ff, held_in;
   logic [cpcs_pkg::VoltWidth-1:0]   out_ff;

   logic [16:0]        diff;
   logic [31:0]        scaled;
   logic signed [19:0] delta;
   logic signed [11:0] step;
   logic signed [19:0] held_sum;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_offset_ff <= '0;
         cal_gain_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            cpcs_pkg::CsrCalOffset: cal_offset_ff <= csr_wdata[cpcs_pkg::OffsetWidth-1:0];
            cpcs_pkg::CsrCalGain:   cal_gain_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // inverted sample minus offset, negative counts become zero
   assign diff     = {1'b0, ~sample} - {1'b0, cal_offset_ff};
   assign count_in = diff[16] ? '0 : diff[15:0];

   // volts from product, saturated at 5 V
   assign scaled   = prod_ff[ProdWidth-1:16];
   assign volts_in = (scaled > {13'd0, cpcs_pkg::VoltMax}) ? cpcs_pkg::VoltMax
                                                            : scaled[cpcs_pkg::VoltWidth-1:0];

   // distance to held value and jump test
   assign delta   = $signed({1'b0, volts_in}) - $signed({1'b0, held_ff});
   assign jump_in = (delta > cpcs_pkg::JumpLimit) || (delta < -cpcs_pkg::JumpLimit);
   assign sprod_in = 29'($signed(delta[12:0])) * 29'(cpcs_pkg::SmoothCoef);

   // floor shift of the smoothing product, then accumulate
   assign step     = sprod_ff[27:16];
   assign held_sum = $signed({1'b0, held_ff}) + 20'(step);
   assign held_in  = jump_ff ? volts_ff : held_sum[cpcs_pkg::VoltWidth-1:0];

   // held value is control state, reset to zero volts
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (cmd.wb) begin
         held_ff <= held_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         count_ff <= count_in;
      end
      if (cmd.mul) begin
         prod_ff <= ProdWidth'(count_ff) * ProdWidth'(cal_gain_ff);
      end
      if (cmd.step) begin
         volts_ff <= volts_in;
         jump_ff  <= jump_in;
         sprod_ff <= sprod_in;
      end
      if (cmd.wb) begin
         out_ff <= held_in - cpcs_pkg::OutBias;
      end
   end

   assign pitch_volts = out_ff;

endmodule

### src/cv_pitch_calibrate_smooth.sv
// Pitch control-voltage calibration and smoothing, top level.
//
// req_* carries one 16-bit converter sample per transfer. The sample is
// inverted, corrected by cal_offset, scaled by cal_gain to Q3.16 volts
// (1 V = 65536) and clamped to 0..5 V. A move of more than 1/24 V makes the
// held value jump; smaller moves are filtered with a 0.2 one-pole step.
// rsp_* returns one value per sample: held volts minus 2 V, signed Q3.16.
// csr_* writes cal_offset (index 0) and cal_gain (index 1).
//
// A result is shown on a one-entry output register. The controller walks
// accept, multiply, smoothing and write-back in turn around the held-value
// loop, so a new sample is taken only after write-back of the last one.
// A new sample is taken while the last result still waits; if the
// receiver stalls, write-back of the following sample waits until the
// output register drains.
// Reset clears the calibration registers, the held value and rsp_tvalid.
//
// depends on cpcs_pkg, cpcs_ctrl, cpcs_dpath

module cv_pitch_calibrate_smooth (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cpcs_pkg::ReqDataWidth-1:0]   req_tdata,   // [15:0] sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cpcs_pkg::RspDataWidth-1:0]   rsp_tdata,   // [18:0] pitch_volts, rest zero
   input  logic                                csr_we,
   input  logic [cpcs_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [cpcs_pkg::CsrDataWidth-1:0]   csr_wdata
);

   cpcs_pkg::cmd_type              cmd;
   logic [cpcs_pkg::VoltWidth-1:0] pitch_volts;

   // sequencer
   cpcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // arithmetic
   cpcs_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sample      (req_tdata[cpcs_pkg::SampleWidth-1:0]),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .pitch_volts (pitch_volts)
   );

   // pad result to whole bytes
   assign rsp_tdata = {{(cpcs_pkg::RspDataWidth - cpcs_pkg::VoltWidth){1'b0}}, pitch_volts};

endmodule

### src/cpcs_checker.sv
// cpcs_checker: port-level assertions for cv_pitch_calibrate_smooth
// depends on cpcs_pkg; bound to the top level below

module cpcs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [cpcs_pkg::RspDataWidth-1:0] rsp_tdata
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // a stalled result keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // after a sample transfer no new sample is taken during multiply, smoothing and write-back
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready ##1 !req_tready)
      else $error("sample taken during processing");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind cv_pitch_calibrate_smooth cpcs_checker u_cpcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
